### rtl/itp_pkg.sv
// Package: shared types, character codes and operator ranking for the infix-to-postfix converter.
package itp_pkg;

  localparam int SYM_W           = 8;
  localparam int RANK_W          = 4;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [SYM_W-1:0] CH_NOT   = 8'h21;  // '!'
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B;  // '+'
  localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D;  // '-'
  localparam logic [SYM_W-1:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;  // ')'

  localparam logic [RANK_W-1:0] RANK_NONE = 4'd0;
  localparam logic [RANK_W-1:0] RANK_NOT  = 4'd10;
  localparam logic [RANK_W-1:0] RANK_MUL  = 4'd3;
  localparam logic [RANK_W-1:0] RANK_ADD  = 4'd2;
  localparam logic [RANK_W-1:0] RANK_GT   = 4'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_UNMATCHED  = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_RESERVED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_OPERAND,
    K_OPEN,
    K_CLOSE,
    K_OPER,
    K_END
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  sym;
    logic [RANK_W-1:0] rank;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_EVAL,
    S_PUSH,
    S_FLUSH,
    S_ERR
  } state_t;

  // Operators (the binary ones and unary '!') rank 1 and up; anything else (including '(') ranks zero.
  function automatic logic [RANK_W-1:0] rank_of(input logic [SYM_W-1:0] c);
    logic [RANK_W-1:0] r;
    unique case (c)
      CH_NOT:          r = RANK_NOT;
      CH_MUL, CH_DIV:  r = RANK_MUL;
      CH_ADD, CH_SUB:  r = RANK_ADD;
      CH_GT:           r = RANK_GT;
      default:         r = RANK_NONE;
    endcase
    return r;
  endfunction

endpackage

### rtl/itp_if.sv
// Interfaces: input character channel and postfix result channel.
interface itp_in_if;
  logic                         valid;
  logic                         ready;
  logic [itp_pkg::SYM_W-1:0]    symbol;
  logic                         is_end;

  modport source (output valid, output symbol, output is_end, input ready);
  modport sink   (input valid, input symbol, input is_end, output ready);
endinterface

interface itp_out_if;
  logic                         valid;
  logic                         ready;
  logic [itp_pkg::SYM_W-1:0]    out_symbol;
  logic                         has_symbol;
  logic                         run_last;
  logic                         expression_done;
  logic [itp_pkg::STATUS_W-1:0] status;

  modport source (output valid, output out_symbol, output has_symbol, output run_last,
                  output expression_done, output status, input ready);
  modport sink   (input valid, input out_symbol, input has_symbol, input run_last,
                  input expression_done, input status, output ready);
endinterface

### rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/itp_front.sv
// Front end: accept characters, classify them and queue commands for the back end.
module itp_front (
  input  logic            clk,
  input  logic            rst_n,
  itp_in_if.sink          in_ch,
  output logic            cmd_valid,
  output itp_pkg::cmd_t   cmd,
  input  logic            cmd_ready
);

  itp_pkg::cmd_t             cls;
  logic [itp_pkg::RANK_W-1:0] rnk;

  itp_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          push, pop;

  // classify
  always_comb begin
    rnk      = itp_pkg::rank_of(in_ch.symbol);
    cls.sym  = in_ch.symbol;
    cls.rank = rnk;
    priority if (in_ch.is_end) begin
      cls.kind = itp_pkg::K_END;
    end else if (in_ch.symbol == itp_pkg::CH_OPEN) begin
      cls.kind = itp_pkg::K_OPEN;
    end else if (in_ch.symbol == itp_pkg::CH_CLOSE) begin
      cls.kind = itp_pkg::K_CLOSE;
    end else if (rnk != itp_pkg::RANK_NONE) begin
      cls.kind = itp_pkg::K_OPER;
    end else begin
      cls.kind = itp_pkg::K_OPERAND;
    end
  end

  // two-entry command queue
  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### rtl/itp_back.sv
// Back end: operator stack sequencer and output register.
module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  itp_pkg::cmd_t cmd,
  output logic          cmd_ready,
  itp_out_if.source     out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  itp_pkg::state_t state_r, state_nxt;
  itp_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [itp_pkg::SYM_W-1:0] pend_r, pend_nxt;
  logic            pend_v_r, pend_v_nxt;

  logic [CW-1:0]   cnt_m1, cnt_m2;
  logic            cnt_one;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr;
  logic [itp_pkg::SYM_W-1:0] top;
  logic            pop_ok;

  logic            out_free;
  logic            emit;
  logic [itp_pkg::SYM_W-1:0] e_sym;
  logic            e_has, e_last, e_done;
  itp_pkg::status_t e_st;

  logic            out_valid_r, out_valid_nxt;
  logic [itp_pkg::SYM_W-1:0] o_sym_r;
  logic            o_has_r, o_last_r, o_done_r;
  itp_pkg::status_t o_st_r;

  itp_ram #(
    .WIDTH (itp_pkg::SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (cmd_r.sym),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (top)
  );

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign cnt_one  = (cnt_r == CW'(1));
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    unique case (cmd_r.kind)
      itp_pkg::K_CLOSE: pop_ok = (top != itp_pkg::CH_OPEN);
      itp_pkg::K_OPER:  pop_ok = (itp_pkg::rank_of(top) >= cmd_r.rank);
      default:          pop_ok = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cnt_m1[AW-1:0];
    wr_en      = 1'b0;
    emit       = 1'b0;
    e_sym      = '0;
    e_has      = 1'b0;
    e_last     = 1'b0;
    e_done     = 1'b0;
    e_st       = itp_pkg::ST_OK;

    unique case (state_r)
      itp_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt    = cmd;
          pend_v_nxt = 1'b0;
          state_nxt  = itp_pkg::S_START;
        end
      end

      itp_pkg::S_START: begin
        unique case (cmd_r.kind)
          itp_pkg::K_OPERAND: begin
            if (out_free) begin
              emit      = 1'b1;
              e_sym     = cmd_r.sym;
              e_has     = 1'b1;
              e_last    = 1'b1;
              state_nxt = itp_pkg::S_IDLE;
            end
          end
          itp_pkg::K_OPEN: begin
            state_nxt = itp_pkg::S_PUSH;
          end
          default: begin
            if (cnt_r == '0) begin
              unique case (cmd_r.kind)
                itp_pkg::K_END: begin
                  if (out_free) begin
                    emit      = 1'b1;
                    e_last    = 1'b1;
                    e_done    = 1'b1;
                    state_nxt = itp_pkg::S_IDLE;
                  end
                end
                itp_pkg::K_CLOSE: state_nxt = itp_pkg::S_ERR;
                default:          state_nxt = itp_pkg::S_PUSH;
              endcase
            end else begin
              rd_en     = 1'b1;
              rd_addr   = cnt_m1[AW-1:0];
              state_nxt = itp_pkg::S_EVAL;
            end
          end
        endcase
      end

      itp_pkg::S_EVAL: begin
        priority if (cmd_r.kind == itp_pkg::K_END) begin
          // flush: last flushed symbol closes the expression
          if (out_free) begin
            emit    = 1'b1;
            e_sym   = top;
            e_has   = 1'b1;
            e_last  = cnt_one;
            e_done  = cnt_one;
            cnt_nxt = cnt_m1;
            if (cnt_one) begin
              state_nxt = itp_pkg::S_IDLE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = cnt_m2[AW-1:0];
            end
          end
        end else if (!pop_ok) begin
          if (cmd_r.kind == itp_pkg::K_CLOSE) begin
            // drop the matching '('
            cnt_nxt   = cnt_m1;
            state_nxt = pend_v_r ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
          end else begin
            state_nxt = itp_pkg::S_PUSH;
          end
        end else begin
          // hold each popped symbol until the next top shows whether it is the last
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              emit  = 1'b1;
              e_sym = pend_r;
              e_has = 1'b1;
            end
            pend_nxt   = top;
            pend_v_nxt = 1'b1;
            cnt_nxt    = cnt_m1;
            if (cnt_one) begin
              state_nxt = (cmd_r.kind == itp_pkg::K_CLOSE) ? itp_pkg::S_ERR
                                                            : itp_pkg::S_PUSH;
            end else begin
              rd_en   = 1'b1;
              rd_addr = cnt_m2[AW-1:0];
            end
          end
        end
      end

      itp_pkg::S_PUSH: begin
        if (cnt_r >= CW'(STACK_DEPTH)) begin
          if (out_free) begin
            emit      = 1'b1;
            e_last    = 1'b1;
            e_done    = 1'b1;
            e_st      = itp_pkg::ST_OVERFLOW;
            cnt_nxt   = '0;
            state_nxt = itp_pkg::S_IDLE;
          end
        end else begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = pend_v_r ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
        end
      end

      itp_pkg::S_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          e_sym      = pend_r;
          e_has      = 1'b1;
          e_last     = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = itp_pkg::S_IDLE;
        end
      end

      itp_pkg::S_ERR: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_v_r) begin
            e_sym      = pend_r;
            e_has      = 1'b1;
            pend_v_nxt = 1'b0;
          end else begin
            e_last    = 1'b1;
            e_done    = 1'b1;
            e_st      = itp_pkg::ST_UNMATCHED;
            state_nxt = itp_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = itp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itp_pkg::S_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    if (emit) begin
      o_sym_r  <= e_sym;
      o_has_r  <= e_has;
      o_last_r <= e_last;
      o_done_r <= e_done;
      o_st_r   <= e_st;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_symbol      = o_sym_r;
  assign out_ch.has_symbol      = o_has_r;
  assign out_ch.run_last        = o_last_r;
  assign out_ch.expression_done = o_done_r;
  assign out_ch.status          = o_st_r;

endmodule

### rtl/infix_to_postfix_converter.sv
// Top level: shunting-yard infix-to-postfix converter with a RAM operator stack.
//
// One character of an infix expression enters per input transaction; postfix symbols
// leave as result transactions, each tagged with run_last on the final result of its
// character and expression_done on the final result of a flush or an error. The front
// end classifies characters into a two-entry command queue, so input transactions keep
// flowing while the back end works; the back end walks the operator stack held in a
// STACK_DEPTH-entry RAM with a registered read port. The single RAM read port delivers
// one stacked symbol per cycle while the output register is free, and each popped symbol
// other than a dropped '(' is one result. An operator that stops on a lower ranked top
// fetches the top, pops, looks once at the remaining top, pushes and then sends the held
// last result.
// Results sit in an output register; the back end stalls only when it has a new result
// and the register still holds one that has not been taken. No clearing pass is
// needed after reset; the stack is ready on the first cycle out of reset.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itp_in_if.sink     in_ch,
  itp_out_if.source  out_ch
);

  logic          cmd_valid;
  logic          cmd_ready;
  itp_pkg::cmd_t cmd;

  // Accept, classify and queue characters.
  itp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Pop, push and flush the operator stack; drive results.
  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );

endmodule

### bench/infix_to_postfix_converter_tb.sv
// Testbench: feeds infix characters to the converter and checks every postfix result against a model.
module infix_to_postfix_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYM_W        = itp_pkg::SYM_W;
  localparam int STACK_DEPTH  = itp_pkg::STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 200_000;
  // Covers back-end work that emits nothing, including the two more commands that can sit
  // in the queue; leave plenty of slack.
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;

  // Rank markers for the parentheses; real operators rank 1 and up, operands 0.
  localparam int RANK_OPEN_MARK  = -1;
  localparam int RANK_CLOSE_MARK = -2;

  // One postfix symbol the converter owes us, in output order.
  typedef struct {
    logic [SYM_W-1:0] sym;
    logic             has;
    logic             last;
    logic             done;
    itp_pkg::status_t status;
  } postfix_sym_t;

  // One input character transaction, or an end marker when fin is set.
  typedef struct packed {
    logic             fin;
    logic [SYM_W-1:0] sym;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n;

  itp_in_if  in_ch();
  itp_out_if out_ch();

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: the operator stack as the converter should hold it.
  logic [SYM_W-1:0] op_stack [STACK_DEPTH];
  int unsigned      op_depth;

  postfix_sym_t pending_syms[$];   // symbols still owed by the converter
  char_item_t   char_plan[$];      // characters queued for the next burst of sends
  postfix_sym_t due_sym;

  int unsigned items_sent;
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned idle_send_pct;
  int unsigned stall_recv_pct;

  // ---------------------------------------------------------------------------
  // Shunting-yard model
  // ---------------------------------------------------------------------------

  function automatic int op_rank(logic [SYM_W-1:0] c);
    case (c)
      itp_pkg::CH_NOT:                  return int'(itp_pkg::RANK_NOT);
      itp_pkg::CH_MUL, itp_pkg::CH_DIV: return int'(itp_pkg::RANK_MUL);
      itp_pkg::CH_ADD, itp_pkg::CH_SUB: return int'(itp_pkg::RANK_ADD);
      itp_pkg::CH_GT:                   return int'(itp_pkg::RANK_GT);
      itp_pkg::CH_OPEN:                 return RANK_OPEN_MARK;
      itp_pkg::CH_CLOSE:                return RANK_CLOSE_MARK;
      default:                          return 0;
    endcase
  endfunction

  function automatic void owe_sym(logic [SYM_W-1:0] s, logic has, logic done,
                                  itp_pkg::status_t st);
    postfix_sym_t e;
    e.sym    = has ? s : '0;
    e.has    = has;
    e.last   = 1'b0;
    e.done   = done;
    e.status = st;
    pending_syms.push_back(e);
  endfunction

  // Advance the stack model by one accepted character and queue what it emits.
  function automatic void convert_char(logic [SYM_W-1:0] c, logic fin);
    int unsigned      n0;
    int               r;
    logic             found;
    logic [SYM_W-1:0] t;
    n0 = pending_syms.size();
    if (fin) begin
      // Flush: leftover '(' come out too; the final one closes the expression.
      if (op_depth == 0) begin
        owe_sym('0, 1'b0, 1'b1, itp_pkg::ST_OK);
      end else begin
        while (op_depth > 0) begin
          op_depth--;
          owe_sym(op_stack[op_depth], 1'b1, op_depth == 0, itp_pkg::ST_OK);
        end
      end
    end else begin
      r = op_rank(c);
      if (r == 0) begin
        owe_sym(c, 1'b1, 1'b0, itp_pkg::ST_OK);
      end else if (r == RANK_CLOSE_MARK) begin
        // Pop down to the matching '(' and drop it; an empty stack means no match.
        found = 1'b0;
        while (op_depth > 0 && !found) begin
          op_depth--;
          t = op_stack[op_depth];
          if (t == itp_pkg::CH_OPEN) begin
            found = 1'b1;
          end else begin
            owe_sym(t, 1'b1, 1'b0, itp_pkg::ST_OK);
          end
        end
        if (!found) owe_sym('0, 1'b0, 1'b1, itp_pkg::ST_UNMATCHED);
      end else begin
        if (r > 0) begin
          while (op_depth > 0 && op_rank(op_stack[op_depth-1]) >= r) begin
            op_depth--;
            owe_sym(op_stack[op_depth], 1'b1, 1'b0, itp_pkg::ST_OK);
          end
        end
        // A push onto a full stack is dropped and the stack cleared.
        if (op_depth >= STACK_DEPTH) begin
          op_depth = 0;
          owe_sym('0, 1'b0, 1'b1, itp_pkg::ST_OVERFLOW);
        end else begin
          op_stack[op_depth] = c;
          op_depth++;
        end
      end
    end
    if (pending_syms.size() > n0) pending_syms[pending_syms.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  function automatic void plan_char(logic [SYM_W-1:0] s);
    char_item_t it;
    it.fin = 1'b0;
    it.sym = s;
    char_plan.push_back(it);
  endfunction

  // End marker; the symbol bits ride along random since the converter ignores them.
  function automatic void plan_end();
    char_item_t it;
    it.fin = 1'b1;
    it.sym = SYM_W'($urandom_range(0, 255));
    char_plan.push_back(it);
  endfunction

  function automatic logic [SYM_W-1:0] pick_operand();
    logic [SYM_W-1:0] s;
    if ($urandom_range(0, 1) == 0) return SYM_W'(8'h61 + $urandom_range(0, 25));
    do s = SYM_W'($urandom_range(0, 255)); while (op_rank(s) != 0);
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_MUL;
      1:       return itp_pkg::CH_DIV;
      2:       return itp_pkg::CH_ADD;
      3:       return itp_pkg::CH_SUB;
      default: return itp_pkg::CH_GT;
    endcase
  endfunction

  // term := operand | '!' term | '(' expr ')'
  function automatic void plan_term(int lvl);
    if (lvl < 4 && $urandom_range(0, 3) == 0) begin
      plan_char(itp_pkg::CH_OPEN);
      plan_expr(lvl + 1);
      plan_char(itp_pkg::CH_CLOSE);
    end else if ($urandom_range(0, 5) == 0) begin
      plan_char(itp_pkg::CH_NOT);
      plan_term(lvl);
    end else begin
      plan_char(pick_operand());
    end
  endfunction

  // expr := term (operator term)*
  function automatic void plan_expr(int lvl);
    plan_term(lvl);
    repeat ($urandom_range(0, (lvl < 2) ? 4 : 2)) begin
      plan_char(pick_operator());
      plan_term(lvl);
    end
  endfunction

  // Open n parentheses with operands sprinkled in, close a few, then end.
  function automatic void plan_deep_nest(int n, int closes);
    for (int i = 0; i < n; i++) begin
      plan_char(itp_pkg::CH_OPEN);
      if ($urandom_range(0, 3) == 0) plan_char(pick_operand());
    end
    repeat (closes) plan_char(itp_pkg::CH_CLOSE);
    plan_end();
  endfunction

  // Mostly well-formed expressions with random content; the rest noise and broken ones.
  function automatic void plan_random_sequence();
    int unsigned sel;
    int unsigned pos;
    char_item_t  it;
    sel = $urandom_range(0, 19);
    if (sel <= 13) begin
      plan_expr(0);
      plan_end();
    end else if (sel <= 15) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 5) == 0) plan_end();
        else plan_char(SYM_W'($urandom_range(0, 255)));
      end
    end else if (sel <= 17) begin
      plan_expr(0);
      pos = $urandom_range(0, char_plan.size() - 1);
      if ($urandom_range(0, 1) == 0) begin
        char_plan.delete(pos);
      end else begin
        it.fin = 1'b0;
        it.sym = ($urandom_range(0, 1) == 0) ? itp_pkg::CH_CLOSE : itp_pkg::CH_OPEN;
        char_plan.insert(pos, it);
      end
      if ($urandom_range(0, 1) == 0) plan_end();
    end else if (sel == 18) begin
      plan_deep_nest($urandom_range(12, 19), $urandom_range(0, 3));
    end else begin
      // Stray ')' after a complete expression.
      plan_expr(0);
      plan_char(itp_pkg::CH_CLOSE);
      plan_end();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  // Drive one transaction and hold it until accepted; valid stays up for the next one.
  task automatic send_char(char_item_t it);
    while (idle_send_pct != 0 && $urandom_range(1, 100) <= idle_send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= it.sym;
    in_ch.is_end <= it.fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    convert_char(it.sym, it.fin);
    items_sent++;
  endtask

  task automatic run_plan();
    char_item_t it;
    while (char_plan.size() != 0) begin
      it = char_plan[0];
      char_plan.delete(0);
      send_char(it);
    end
  endtask

  // Drop valid and hold off until every owed symbol has come out, then let the
  // back end finish any push that produces no result.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    idle_send_pct  = send_pct;
    stall_recv_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operand extremes pass straight through; an end on an empty stack closes at once.
  task automatic test_operands_and_bounds();
    plan_char(8'h00);
    plan_char(8'hFF);
    plan_char(8'h61);
    plan_end();
    run_plan();
  endtask

  // a>b+c*!d-e/f then end: every operator, equal-rank pops and a flush of stacked ops.
  task automatic test_operator_ranks();
    plan_char(8'h61); plan_char(itp_pkg::CH_GT);
    plan_char(8'h62); plan_char(itp_pkg::CH_ADD);
    plan_char(8'h63); plan_char(itp_pkg::CH_MUL);
    plan_char(itp_pkg::CH_NOT); plan_char(8'h64);
    plan_char(itp_pkg::CH_SUB);
    plan_char(8'h65); plan_char(itp_pkg::CH_DIV);
    plan_char(8'h66);
    plan_end();
    run_plan();
  endtask

  // (a)*b) then end: matched pair, then a ')' that pops '*' and finds no match.
  task automatic test_parentheses();
    plan_char(itp_pkg::CH_OPEN);
    plan_char(8'h61);
    plan_char(itp_pkg::CH_CLOSE);
    plan_char(itp_pkg::CH_MUL);
    plan_char(8'h62);
    plan_char(itp_pkg::CH_CLOSE);
    plan_end();
    run_plan();
  endtask

  // A full stack flushed by an end, then two runs that push one and two past the top.
  task automatic test_stack_limits();
    plan_deep_nest(STACK_DEPTH, 0);
    plan_deep_nest(STACK_DEPTH + 1, 0);
    plan_deep_nest(STACK_DEPTH + 2, 1);
    run_plan();
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      plan_random_sequence();
      run_plan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result channel at the current rate; zero means always ready.
  always @(posedge clk) begin
    out_ch.ready <= (stall_recv_pct == 0) || ($urandom_range(1, 100) > stall_recv_pct);
  end

  // Compare each result transaction with the oldest owed symbol.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_syms.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: unexpected result sym=%h has=%b last=%b done=%b status=%0d",
                   out_ch.out_symbol, out_ch.has_symbol, out_ch.run_last,
                   out_ch.expression_done, out_ch.status);
      end else begin
        due_sym = pending_syms[0];
        pending_syms.delete(0);
        if (out_ch.out_symbol !== due_sym.sym || out_ch.has_symbol !== due_sym.has ||
            out_ch.run_last !== due_sym.last || out_ch.expression_done !== due_sym.done ||
            out_ch.status !== due_sym.status) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("ERROR: result mismatch exp sym=%h has=%b last=%b done=%b status=%0d, %s",
                     due_sym.sym, due_sym.has, due_sym.last, due_sym.done, due_sym.status,
                     $sformatf("got sym=%h has=%b last=%b done=%b status=%0d",
                               out_ch.out_symbol, out_ch.has_symbol, out_ch.run_last,
                               out_ch.expression_done, out_ch.status));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    items_sent     = 0;
    errors         = 0;
    cycle_count    = 0;
    op_depth       = 0;
    idle_send_pct  = 0;
    stall_recv_pct = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.symbol <= '0;
    in_ch.is_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks with both sides streaming.
    test_operands_and_bounds();
    test_operator_ranks();
    test_parentheses();
    hold_until_drained();

    // Random traffic, one idling pattern per phase; drain between phases.
    test_random_traffic(60);
    hold_until_drained();

    set_idling(46, 0);
    test_random_traffic(55);
    hold_until_drained();

    set_idling(0, 46);
    test_random_traffic(55);
    hold_until_drained();

    set_idling(20, 20);
    test_stack_limits();
    test_random_traffic(45);

    hold_until_drained();
    if (errors == 0) begin
      $display("infix_to_postfix_converter_tb: done, clean");
    end else begin
      $display("infix_to_postfix_converter_tb: done, errors");
    end
    $finish;
  end

endmodule
